/* hdl/hbrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_pkg: shared types and constants for the byte-range parser
// Character codes, prefix text, result kinds and the beat structs that pass
// between the parse, close and output queue stages.
// ----------------------------------------------------------------------------
package hbrp_pkg;

    localparam int VALUE_WIDTH_DEF = 48;   // width of a parsed number
    localparam int FS_W            = 48;   // file size and range offsets
    localparam int OQ_DEPTH        = 4;    // result queue entries

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // register index taken from paddr[3]
    localparam logic REG_FILE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        KIND_RANGE  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FIN_SKIP   = 2'd0,
        FIN_RANGE  = 2'd1,
        FIN_REJECT = 2'd2
    } t_fin;

    typedef struct packed {
        logic [FS_W-1:0] range_start;
        logic [FS_W-1:0] range_end;
        t_kind           kind;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic            valid;
        logic [FS_W-1:0] s;
        logic [FS_W-1:0] e;
    } t_range;

    // entry marks after the current character, for end-of-header evaluation
    typedef struct packed {
        logic eoh;
        logic phase;
        logic dash;
        logic fdig;
        logic sdig;
        logic failed;
    } t_snap;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h62;   // b
            3'd1:    c = 8'h79;   // y
            3'd2:    c = 8'h74;   // t
            3'd3:    c = 8'h65;   // e
            3'd4:    c = 8'h73;   // s
            3'd5:    c = 8'h3D;   // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/http_byte_range_parser_core.sv */
`timescale 1ns / 1ps
// A result is registered in the close stage, then queued, before output.
// Throughput: one header byte per cycle; a beat gives at most two results,
// and the four-entry result queue holds off input only while it lacks room.
// Reset: synchronous, active low; clears file_size, parser state and queue.
// ----------------------------------------------------------------------------
// http_byte_range_parser_core: HTTP Range header parser
// Parses a "bytes=" Range value one byte a beat and streams out ranges and
// a final accepted/rejected verdict per header.
// ----------------------------------------------------------------------------
module http_byte_range_parser_core #(
    parameter int VALUE_WIDTH = hbrp_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // header bytes
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] char_in
    input  logic         s_axis_tlast,    // end_of_header
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,    // [47:0] range_start, [95:48] range_end
    output logic [1:0]   m_axis_tuser,    // [1:0] kind
    output logic         m_axis_tlast     // last
);

    logic [hbrp_pkg::FS_W-1:0] file_size;
    hbrp_pkg::t_snap           snap;
    logic [VALUE_WIDTH-1:0]    snap_first;
    logic [VALUE_WIDTH-1:0]    snap_second;
    hbrp_pkg::t_range          comma;
    hbrp_pkg::t_push           push;
    hbrp_pkg::t_result         m_res;

    hbrp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_file_size (file_size)
    );

    hbrp_parse #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .i_tready    (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_eoh       (s_axis_tlast),
        .i_file_size (file_size),
        .o_snap      (snap),
        .o_first     (snap_first),
        .o_second    (snap_second),
        .o_comma     (comma)
    );

    hbrp_close #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_close (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (snap),
        .i_first     (snap_first),
        .i_second    (snap_second),
        .i_comma     (comma),
        .i_file_size (file_size),
        .o_push      (push)
    );

    hbrp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_res    (m_res),
        .o_s_tready (s_axis_tready)
    );

    assign m_axis_tdata = {m_res.range_end, m_res.range_start};
    assign m_axis_tuser = m_res.kind;
    assign m_axis_tlast = m_res.last;

endmodule

/* hdl/hbrp_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_cfg: configuration register port
// Holds file_size; written by a completed write access, read back as is.
// ----------------------------------------------------------------------------
module hbrp_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output logic [hbrp_pkg::FS_W-1:0]  o_file_size
);

    logic [hbrp_pkg::FS_W-1:0] r_file_size;
    logic                      wr_en;

    // low address bits are don't care: register index sits in paddr[3]
    assign wr_en = psel & penable & pwrite & (paddr[3] == hbrp_pkg::REG_FILE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (wr_en) begin
            r_file_size <= pwdata[hbrp_pkg::FS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3] == hbrp_pkg::REG_FILE_SIZE) begin
            prdata[hbrp_pkg::FS_W-1:0] = r_file_size;
        end
    end

    assign pready      = 1'b1;
    assign o_file_size = r_file_size;

endmodule

/* hdl/hbrp_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_finish: range entry evaluation
// Turns the marks and numbers of one entry into skip, range or reject,
// resolving suffix and open-ended forms against the file size.
// ----------------------------------------------------------------------------
module hbrp_finish #(
    parameter int VALUE_WIDTH = hbrp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_phase,
    input  logic                       i_dash,
    input  logic                       i_fdig,
    input  logic                       i_sdig,
    input  logic [VALUE_WIDTH-1:0]     i_first,
    input  logic [VALUE_WIDTH-1:0]     i_second,
    input  logic [hbrp_pkg::FS_W-1:0]  i_fs,
    output hbrp_pkg::t_fin             o_code,
    output logic [hbrp_pkg::FS_W-1:0]  o_s,
    output logic [hbrp_pkg::FS_W-1:0]  o_e
);

    localparam int FW = hbrp_pkg::FS_W;
    localparam int CW = (VALUE_WIDTH > FW) ? VALUE_WIDTH : FW;

    logic [CW-1:0] fsx;
    logic [CW-1:0] fx;
    logic [CW-1:0] sx;
    logic          f_big;
    logic          s_big;
    logic          fs_zero;
    logic [FW-1:0] fs_m1;
    logic [FW-1:0] sfx_start;

    assign fsx       = CW'(i_fs);
    assign fx        = CW'(i_first);
    assign sx        = CW'(i_second);
    assign f_big     = fx > fsx;
    assign s_big     = sx > fsx;
    assign fs_zero   = (i_fs == '0);
    assign fs_m1     = i_fs - FW'(1);
    assign sfx_start = i_fs - sx[FW-1:0];

    // suffix longer than the file clamps to offset zero
    assign o_s = !i_fdig ? (s_big ? '0 : sfx_start) : fx[FW-1:0];
    assign o_e = (i_fdig && i_sdig) ? sx[FW-1:0] : fs_m1;

    always_comb begin
        if (!i_phase) begin
            o_code = hbrp_pkg::FIN_SKIP;
        end else if (!i_dash) begin
            o_code = hbrp_pkg::FIN_REJECT;
        end else if (!i_fdig) begin
            o_code = (!i_sdig || fs_zero) ? hbrp_pkg::FIN_REJECT : hbrp_pkg::FIN_RANGE;
        end else if (!i_sdig) begin
            o_code = (fs_zero || f_big) ? hbrp_pkg::FIN_REJECT : hbrp_pkg::FIN_RANGE;
        end else begin
            o_code = (f_big || s_big) ? hbrp_pkg::FIN_REJECT : hbrp_pkg::FIN_RANGE;
        end
    end

endmodule

/* hdl/hbrp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_parse: per-character parser state
// Matches the prefix, accumulates digits, tracks dash and entry marks and
// closes an entry on a comma. Hands the post-character state onward.
// ----------------------------------------------------------------------------
module hbrp_parse #(
    parameter int VALUE_WIDTH = hbrp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tvalid,
    input  logic                       i_tready,
    input  logic [7:0]                 i_char,
    input  logic                       i_eoh,
    input  logic [hbrp_pkg::FS_W-1:0]  i_file_size,
    output hbrp_pkg::t_snap            o_snap,
    output logic [VALUE_WIDTH-1:0]     o_first,
    output logic [VALUE_WIDTH-1:0]     o_second,
    output hbrp_pkg::t_range           o_comma
);

    localparam int AW = VALUE_WIDTH + 4;

    logic [2:0]             r_pos,    n_pos,    a_pos;
    logic                   r_phase,  n_phase,  a_phase;
    logic                   r_dash,   n_dash,   a_dash;
    logic                   r_fdig,   n_fdig,   a_fdig;
    logic                   r_sdig,   n_sdig,   a_sdig;
    logic                   r_failed, n_failed, a_failed;
    logic [VALUE_WIDTH-1:0] r_first,  n_first,  a_first;
    logic [VALUE_WIDTH-1:0] r_second, n_second, a_second;

    logic                          fire;
    logic                          eoh_fire;
    logic                          is_digit;
    logic                          cm_hit;
    logic [VALUE_WIDTH-1:0]        tgt;
    logic [AW-1:0]                 acc;
    logic                          acc_ovf;
    hbrp_pkg::t_fin                c_code;
    logic [hbrp_pkg::FS_W-1:0]     c_s;
    logic [hbrp_pkg::FS_W-1:0]     c_e;

    // comma closes the entry as it stood before this character
    hbrp_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_comma_fin (
        .i_phase  (r_phase),
        .i_dash   (r_dash),
        .i_fdig   (r_fdig),
        .i_sdig   (r_sdig),
        .i_first  (r_first),
        .i_second (r_second),
        .i_fs     (i_file_size),
        .o_code   (c_code),
        .o_s      (c_s),
        .o_e      (c_e)
    );

    // v*10 + d; any carry into the top four bits is an overflow
    assign tgt     = r_dash ? r_second : r_first;
    assign acc     = (AW'(tgt) << 3) + (AW'(tgt) << 1) + AW'(i_char[3:0]);
    assign acc_ovf = |acc[AW-1:VALUE_WIDTH];

    assign fire     = i_tvalid & i_tready;
    assign eoh_fire = fire & i_eoh;
    assign is_digit = (i_char >= hbrp_pkg::CH_ZERO) && (i_char <= hbrp_pkg::CH_NINE);

    always_comb begin
        a_pos    = r_pos;
        a_phase  = r_phase;
        a_dash   = r_dash;
        a_fdig   = r_fdig;
        a_sdig   = r_sdig;
        a_failed = r_failed;
        a_first  = r_first;
        a_second = r_second;
        cm_hit   = 1'b0;

        if (fire && !r_failed) begin
            if (r_pos != hbrp_pkg::PREFIX_LEN) begin
                if (i_char == hbrp_pkg::prefix_char(r_pos)) begin
                    a_pos = r_pos + 3'd1;
                end else begin
                    a_failed = 1'b1;
                end
            end else if (is_digit) begin
                a_phase = 1'b1;
                if (!r_dash) begin
                    a_fdig = 1'b1;
                end else begin
                    a_sdig = 1'b1;
                end
                if (acc_ovf) begin
                    a_failed = 1'b1;
                end else if (!r_dash) begin
                    a_first = acc[VALUE_WIDTH-1:0];
                end else begin
                    a_second = acc[VALUE_WIDTH-1:0];
                end
            end else if (i_char == hbrp_pkg::CH_DASH) begin
                if (r_dash) begin
                    a_failed = 1'b1;
                end
                a_dash  = 1'b1;
                a_phase = 1'b1;
            end else if (i_char == hbrp_pkg::CH_COMMA) begin
                case (c_code)
                    hbrp_pkg::FIN_RANGE:  cm_hit   = 1'b1;
                    hbrp_pkg::FIN_REJECT: a_failed = 1'b1;
                    default: ;
                endcase
                a_phase  = 1'b0;
                a_dash   = 1'b0;
                a_fdig   = 1'b0;
                a_sdig   = 1'b0;
                a_first  = '0;
                a_second = '0;
            end else if (!((i_char == hbrp_pkg::CH_SPACE) && !r_phase)) begin
                a_failed = 1'b1;
            end
        end

        // header ends: everything returns to the reset state
        if (eoh_fire) begin
            n_pos    = '0;
            n_phase  = 1'b0;
            n_dash   = 1'b0;
            n_fdig   = 1'b0;
            n_sdig   = 1'b0;
            n_failed = 1'b0;
            n_first  = '0;
            n_second = '0;
        end else begin
            n_pos    = a_pos;
            n_phase  = a_phase;
            n_dash   = a_dash;
            n_fdig   = a_fdig;
            n_sdig   = a_sdig;
            n_failed = a_failed;
            n_first  = a_first;
            n_second = a_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= 1'b0;
            r_dash   <= 1'b0;
            r_fdig   <= 1'b0;
            r_sdig   <= 1'b0;
            r_failed <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_dash   <= n_dash;
            r_fdig   <= n_fdig;
            r_sdig   <= n_sdig;
            r_failed <= n_failed;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // header cut short inside the prefix counts as failed
    assign o_snap.eoh    = eoh_fire;
    assign o_snap.phase  = a_phase;
    assign o_snap.dash   = a_dash;
    assign o_snap.fdig   = a_fdig;
    assign o_snap.sdig   = a_sdig;
    assign o_snap.failed = a_failed | (a_pos != hbrp_pkg::PREFIX_LEN);
    assign o_first       = a_first;
    assign o_second      = a_second;
    assign o_comma.valid = cm_hit;
    assign o_comma.s     = c_s;
    assign o_comma.e     = c_e;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= hbrp_pkg::PREFIX_LEN)
        else $error("prefix position past end of prefix");

    a_eoh_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eoh_fire |=> (r_pos == 3'd0) && !r_failed && !r_phase && !r_dash)
        else $error("parser state not cleared after end of header");
`endif

endmodule

/* hdl/hbrp_close.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_close: result stage
// Registers the parser output, evaluates the last entry at end of header and
// lines up the comma range, final range and verdict as queue pushes.
// ----------------------------------------------------------------------------
module hbrp_close #(
    parameter int VALUE_WIDTH = hbrp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hbrp_pkg::t_snap            i_snap,
    input  logic [VALUE_WIDTH-1:0]     i_first,
    input  logic [VALUE_WIDTH-1:0]     i_second,
    input  hbrp_pkg::t_range           i_comma,
    input  logic [hbrp_pkg::FS_W-1:0]  i_file_size,
    output hbrp_pkg::t_push            o_push
);

    hbrp_pkg::t_snap           r_snap;
    logic [VALUE_WIDTH-1:0]    r_first;
    logic [VALUE_WIDTH-1:0]    r_second;
    hbrp_pkg::t_range          r_comma;

    hbrp_pkg::t_fin            f_code;
    logic [hbrp_pkg::FS_W-1:0] f_s;
    logic [hbrp_pkg::FS_W-1:0] f_e;
    logic                      rng_ok;
    hbrp_pkg::t_result         res_comma;
    hbrp_pkg::t_result         res_eoh;
    hbrp_pkg::t_result         res_final;

    // only the strobes need a reset; the data follows them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap.eoh    <= 1'b0;
            r_comma.valid <= 1'b0;
        end else begin
            r_snap.eoh    <= i_snap.eoh;
            r_comma.valid <= i_comma.valid;
        end
        r_snap.phase  <= i_snap.phase;
        r_snap.dash   <= i_snap.dash;
        r_snap.fdig   <= i_snap.fdig;
        r_snap.sdig   <= i_snap.sdig;
        r_snap.failed <= i_snap.failed;
        r_first       <= i_first;
        r_second      <= i_second;
        r_comma.s     <= i_comma.s;
        r_comma.e     <= i_comma.e;
    end

    hbrp_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_eoh_fin (
        .i_phase  (r_snap.phase),
        .i_dash   (r_snap.dash),
        .i_fdig   (r_snap.fdig),
        .i_sdig   (r_snap.sdig),
        .i_first  (r_first),
        .i_second (r_second),
        .i_fs     (i_file_size),
        .o_code   (f_code),
        .o_s      (f_s),
        .o_e      (f_e)
    );

    assign rng_ok = r_snap.eoh && !r_snap.failed && (f_code == hbrp_pkg::FIN_RANGE);

    always_comb begin
        res_comma.range_start = r_comma.s;
        res_comma.range_end   = r_comma.e;
        res_comma.kind        = hbrp_pkg::KIND_RANGE;
        res_comma.last        = 1'b0;

        res_eoh.range_start   = f_s;
        res_eoh.range_end     = f_e;
        res_eoh.kind          = hbrp_pkg::KIND_RANGE;
        res_eoh.last          = 1'b0;

        res_final.range_start = '0;
        res_final.range_end   = '0;
        res_final.kind        = (r_snap.failed || (f_code == hbrp_pkg::FIN_REJECT)) ?
                                hbrp_pkg::KIND_REJECT : hbrp_pkg::KIND_ACCEPT;
        res_final.last        = 1'b1;

        // a comma beat leaves an empty entry, so comma range and final
        // range never come together: at most two pushes
        o_push.cnt = 2'(r_comma.valid) + 2'(rng_ok) + 2'(r_snap.eoh);
        o_push.r0  = r_comma.valid ? res_comma : (rng_ok ? res_eoh : res_final);
        o_push.r1  = (r_comma.valid && rng_ok) ? res_eoh : res_final;
    end

`ifndef SYNTHESIS
    a_two_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_comma.valid, rng_ok, r_snap.eoh}) <= 2)
        else $error("more than two results from one beat");
`endif

endmodule

/* hdl/hbrp_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrp_outq: result queue
// Small circular buffer taking up to two results a cycle and presenting one
// per beat on the output; holds off input while room for a burst is short.
// ----------------------------------------------------------------------------
module hbrp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbrp_pkg::t_push    i_push,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output hbrp_pkg::t_result  o_m_res,
    output logic               o_s_tready
);

    localparam int DEPTH = hbrp_pkg::OQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 3);

    hbrp_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              pop;

    assign pop        = o_m_tvalid & i_m_tready;
    assign o_m_tvalid = (r_count != '0);
    assign o_m_res    = r_mem[r_rp];
    assign n_count    = r_count + CW'(i_push.cnt) - CW'(pop);

    // results still in the close stage count against free space
    assign o_s_tready = (r_count + CW'(i_push.cnt)) <= CW'(DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PW'(i_push.cnt);
            r_rp    <= r_rp + PW'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + PW'(1)] <= i_push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + CW'(i_push.cnt)) <= CW'(DEPTH))
        else $error("result queue overflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (i_push.cnt == 2'd0) |=> r_count == $past(r_count) - CW'(1))
        else $error("queue count out of step with reads");
`endif

endmodule
